/* rtl/core/lfam_pkg.sv */
// ============================================================================
// LED fade animation mux - shared package
// Field widths, codes, drive constants and the structs passed between the
// slot table, the drive calculator and the top-level sequencer.
// ============================================================================
package lfam_pkg;

    // Default sizes for the top-level parameters
    localparam int DEF_NUM_SLOTS = 4;
    localparam int DEF_NUM_LEDS  = 12;

    // Field widths
    localparam int LED_MASK_W  = 12;
    localparam int LEVEL_W     = 16;
    localparam int FLIPS_W     = 8;
    localparam int LED_IDX_W   = 4;
    localparam int PATTERN_W   = 8;
    localparam int TIME_W      = 16;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 48;

    // Opcodes (input tuser) and result kinds (output tuser)
    localparam logic OP_START   = 1'b0;
    localparam logic OP_TICK    = 1'b1;
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_DRIVE = 1'b1;

    // Drive constants
    localparam logic [FLIPS_W-1:0]   FLIPS_FOREVER = 8'd255;
    localparam logic [TIME_W-1:0]    MIN_ON        = 16'd2;
    localparam logic [TIME_W-1:0]    MIN_OFF       = 16'd2;
    localparam logic [TIME_W-1:0]    MIN_LEN       = 16'd4;
    localparam logic [TIME_W-1:0]    SLOT_LEN_RST  = 16'd100;
    localparam logic [PATTERN_W-1:0] BLANK_BYTE    = 8'h0F;

    // Shift register byte that lights each LED
    localparam logic [PATTERN_W-1:0] LED_BYTES [12] = '{
        8'h47, 8'h4B, 8'h4D, 8'h4E,
        8'h27, 8'h2B, 8'h2D, 8'h2E,
        8'h17, 8'h1B, 8'h1D, 8'h1E
    };

    // Sequencer command to the slot table
    typedef struct packed {
        logic alloc;    // store a new animation in the first empty slot
        logic advance;  // step the selected slot
    } slot_cmd_t;

    // One LED drive result
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic                 lit;
        logic [TIME_W-1:0]    on_time;
        logic [TIME_W-1:0]    off_time;
    } drive_t;

endpackage

/* rtl/core/led_fade_animation_mux.sv */
// ============================================================================
// LED fade animation mux - top level
// Sequencer, per-LED peak registers, slot length register and result
// register around the slot table and the drive calculator.
// ============================================================================
// Usage:
//   Input transfers on s_*: tuser is the opcode (start or tick), tdata the
//   animation fields. Results leave on m_*: tuser is the kind, tlast marks
//   the final result of an input item.
//   A start returns one acknowledgement, valid the cycle after its transfer.
//   A tick scans the slots (one slot per cycle through the shared advance
//   unit), then emits NUM_LEDS results through the shared drive calculator,
//   one per cycle while the receiver does not stall.
//   One item is processed at a time; s_tready is high only while idle with
//   the result register free or being emptied.
//   A stall on m_tready holds the result register and the sequencer.
//   Reset empties all slots, sets slot length to 100 and drops m_tvalid.
//   cfg_wr_en writes slot_length from cfg_wr_data. The user must write it
//   only while the block is idle; the block itself does not enforce this.
// ============================================================================
module led_fade_animation_mux
    import lfam_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int NUM_LEDS  = DEF_NUM_LEDS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // slot_length register
    input  logic                 cfg_wr_en,
    input  logic [TIME_W-1:0]    cfg_wr_data,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // led_mask[11:0], start_level[27:12], end_level[43:28],
    // step_size[59:44], flip_count[67:60], zero pad[71:68]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                 s_tuser,
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accepted[0], led_index[4:1], drive_pattern[12:5], lit[13],
    // on_time[29:14], off_time[45:30], zero pad[47:46]
    output logic [M_TDATA_W-1:0] m_tdata,
    // kind[0]
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [LW-1:0]        led_reg, led_next;
    logic [TIME_W-1:0]    slot_length_reg;
    logic [LEVEL_W-1:0]   peak_reg [NUM_LEDS];

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;

    logic                 out_free;
    logic                 s_accept;
    logic                 tick_accept;
    logic                 slot_last;
    logic                 led_last;
    slot_cmd_t            cmd;
    logic                 alloc_ok;
    logic [LED_MASK_W-1:0] rd_mask;
    logic [LEVEL_W-1:0]   rd_level;
    drive_t               drive;
    logic [LED_IDX_W-1:0] led_idx;

    assign out_free    = !m_valid_reg || m_tready;
    assign s_tready    = (state_reg == S_IDLE) && out_free;
    assign s_accept    = s_tvalid && s_tready;
    assign tick_accept = s_accept && (s_tuser == OP_TICK);
    assign slot_last   = (slot_reg == SW'(NUM_SLOTS - 1));
    assign led_last    = (led_reg == LW'(NUM_LEDS - 1));
    assign led_idx     = LED_IDX_W'(led_reg);

    assign cmd.alloc   = s_accept && (s_tuser == OP_START);
    assign cmd.advance = (state_reg == S_SCAN);

    lfam_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slots (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .idx       (slot_reg),
        .new_mask  (s_tdata[11:0]),
        .new_start (s_tdata[27:12]),
        .new_end   (s_tdata[43:28]),
        .new_step  (s_tdata[59:44]),
        .new_flips (s_tdata[67:60]),
        .alloc_ok  (alloc_ok),
        .rd_mask   (rd_mask),
        .rd_level  (rd_level)
    );

    lfam_drive_calc u_calc (
        .peak        (peak_reg[led_reg]),
        .slot_length (slot_length_reg),
        .led         (led_idx),
        .drive       (drive)
    );

    // Sequencer and result register next values
    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        led_next     = led_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == OP_TICK) begin
                        slot_next  = '0;
                        state_next = S_SCAN;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = {{(M_TDATA_W - 1){1'b0}}, alloc_ok};
                        m_user_next  = KIND_ACK;
                        m_last_next  = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                slot_next = slot_reg + 1'b1;
                if (slot_last) begin
                    led_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, drive.off_time, drive.on_time, drive.lit,
                                    drive.pattern, led_idx, 1'b0};
                    m_user_next  = KIND_DRIVE;
                    m_last_next  = led_last;
                    led_next     = led_reg + 1'b1;
                    if (led_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            slot_length_reg <= SLOT_LEN_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                slot_length_reg <= cfg_wr_data;
            end
        end
    end

    // Counters and result payload
    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        led_reg    <= led_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    // Clear peaks on a tick, then keep the brightest covering slot
    always_ff @(posedge aclk) begin
        for (int d = 0; d < NUM_LEDS; d++) begin
            if (tick_accept) begin
                peak_reg[d] <= '0;
            end else if (state_reg == S_SCAN && rd_mask[d] && rd_level > peak_reg[d]) begin
                peak_reg[d] <= rd_level;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/core/lfam_slot_table.sv */
// ============================================================================
// LED fade animation mux - slot table
// Holds the animation slots, allocates the first empty slot on a start and
// advances one selected slot per cycle through a shared add/compare unit.
// ============================================================================
module lfam_slot_table
    import lfam_pkg::*;
#(
    parameter  int NUM_SLOTS = DEF_NUM_SLOTS,
    localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  slot_cmd_t             cmd,
    input  logic [SW-1:0]         idx,
    input  logic [LED_MASK_W-1:0] new_mask,
    input  logic [LEVEL_W-1:0]    new_start,
    input  logic [LEVEL_W-1:0]    new_end,
    input  logic [LEVEL_W-1:0]    new_step,
    input  logic [FLIPS_W-1:0]    new_flips,
    output logic                  alloc_ok,
    output logic [LED_MASK_W-1:0] rd_mask,
    output logic [LEVEL_W-1:0]    rd_level
);

    logic [LED_MASK_W-1:0] mask_reg  [NUM_SLOTS];
    logic [LEVEL_W-1:0]    level_reg [NUM_SLOTS];
    logic [LEVEL_W-1:0]    start_reg [NUM_SLOTS];
    logic [LEVEL_W-1:0]    end_reg   [NUM_SLOTS];
    logic [LEVEL_W-1:0]    step_reg  [NUM_SLOTS];
    logic [FLIPS_W-1:0]    flips_reg [NUM_SLOTS];

    logic                  found;
    logic [SW-1:0]         free_idx;
    logic [LEVEL_W-1:0]    cur_step;
    logic [LEVEL_W-1:0]    cur_end;
    logic [FLIPS_W-1:0]    cur_flips;
    logic [LEVEL_W-1:0]    sum;
    logic                  active;
    logic                  reached;
    logic                  do_alloc;
    logic                  do_adv;

    // Pick the lowest empty slot
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!found && mask_reg[s] == '0) begin
                found    = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    // Shared advance unit on the selected slot
    assign rd_mask   = mask_reg[idx];
    assign rd_level  = level_reg[idx];
    assign cur_step  = step_reg[idx];
    assign cur_end   = end_reg[idx];
    assign cur_flips = flips_reg[idx];
    assign sum       = rd_level + cur_step;
    assign active    = (rd_mask != '0);

    always_comb begin
        if (cur_step == '0) begin
            reached = 1'b0;
        end else if (cur_step[LEVEL_W-1]) begin
            reached = (sum <= cur_end);
        end else begin
            reached = (sum >= cur_end);
        end
    end

    assign alloc_ok = found;
    assign do_alloc = cmd.alloc && found;
    assign do_adv   = cmd.advance && active;

    // Mask and level: cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                mask_reg[s]  <= '0;
                level_reg[s] <= '0;
            end
        end else if (do_alloc) begin
            mask_reg[free_idx]  <= new_mask;
            level_reg[free_idx] <= new_start;
        end else if (do_adv) begin
            level_reg[idx] <= sum;
            if (reached && cur_flips == '0) begin
                mask_reg[idx] <= '0;
            end
        end
    end

    // Bounds, step and flip count: written before use, no reset
    always_ff @(posedge aclk) begin
        if (do_alloc) begin
            start_reg[free_idx] <= new_start;
            end_reg[free_idx]   <= new_end;
            step_reg[free_idx]  <= new_step;
            flips_reg[free_idx] <= new_flips;
        end else if (do_adv && reached && cur_flips != '0) begin
            start_reg[idx] <= cur_end;
            end_reg[idx]   <= start_reg[idx];
            step_reg[idx]  <= LEVEL_W'(~cur_step + 1'b1);
            if (cur_flips != FLIPS_FOREVER) begin
                flips_reg[idx] <= cur_flips - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/lfam_drive_calc.sv */
// ============================================================================
// LED fade animation mux - drive calculator
// Turns one LED's peak level into its drive byte and on/off times,
// clamped against the slot length.
// ============================================================================
module lfam_drive_calc
    import lfam_pkg::*;
(
    input  logic [LEVEL_W-1:0]   peak,
    input  logic [TIME_W-1:0]    slot_length,
    input  logic [LED_IDX_W-1:0] led,
    output drive_t               drive
);

    logic [TIME_W-1:0] len;
    logic [TIME_W-1:0] on_a;
    logic [TIME_W-1:0] on_t;
    logic [TIME_W-1:0] off_t;

    // Raise the slot length and clamp the on time
    assign len  = (slot_length < MIN_LEN) ? MIN_LEN : slot_length;
    assign on_a = (peak > len) ? len : peak;

    always_comb begin
        if (on_a < MIN_ON) begin
            on_t  = MIN_ON;
            off_t = len - MIN_ON;
        end else begin
            on_t  = on_a;
            off_t = len - on_a;
        end
        if (off_t < MIN_OFF) begin
            off_t = MIN_OFF;
        end
    end

    // Dark LED keeps the written slot length as off time
    always_comb begin
        if (peak == '0) begin
            drive.pattern  = BLANK_BYTE;
            drive.lit      = 1'b0;
            drive.on_time  = '0;
            drive.off_time = slot_length;
        end else begin
            drive.pattern  = LED_BYTES[led];
            drive.lit      = 1'b1;
            drive.on_time  = on_t;
            drive.off_time = off_t;
        end
    end

endmodule
